### hw/rtl/lz77we_pkg.sv
// shared types, constants and helpers of the lz77 window encoder
`default_nettype none

package lz77we_pkg;

    // window size in bytes, also the number of compare cells
    localparam int WINDOW = 30;

    // widths of the token fields
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;

    // broadcast from the control logic to every cell
    typedef struct packed {
        logic              shift;   // a byte is taken this cycle
        logic              keep;    // match goes on, cells keep their hits
        logic              start;   // first byte of a match, every cell is alive
        logic [LEN_W-1:0]  fill;    // window size fixed for this match
        logic [LEN_W-1:0]  len;     // bytes matched so far
        logic [BYTE_W-1:0] data;    // byte under compare
    } cell_ctl_t;

    // index of the highest set bit, 0 when none is set
    function automatic logic [LEN_W-1:0] top_index(input logic [WINDOW-1:0] bits);
        logic [LEN_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (bits[i]) begin
                idx = LEN_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lz77we_if.sv
// byte and token channel interfaces of the lz77 window encoder
`default_nettype none

interface lz77we_byte_if;
    logic                        valid;
    logic                        ready;
    logic [lz77we_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lz77we_token_if;
    logic                         valid;
    logic                         ready;
    logic [lz77we_pkg::LEN_W-1:0]  distance;
    logic [lz77we_pkg::LEN_W-1:0]  match_length;
    logic [lz77we_pkg::BYTE_W-1:0] next_byte;
    logic                         no_next_byte;
    logic                         end_of_string;

    modport source (output valid, output distance, output match_length, output next_byte,
                    output no_next_byte, output end_of_string, input ready);
    modport sink (input valid, input distance, input match_length, input next_byte,
                  input no_next_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### hw/rtl/lz77we_cell.sv
// one window cell: a history byte, its match flag and the byte compare
`default_nettype none

module lz77we_cell #(
    parameter int AGE = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lz77we_pkg::cell_ctl_t         ctl,
    input  wire logic [lz77we_pkg::BYTE_W-1:0] hist_in,
    output logic      [lz77we_pkg::BYTE_W-1:0] hist_out,
    output logic                               hit
);

    localparam logic [lz77we_pkg::LEN_W-1:0] AGE_V = lz77we_pkg::LEN_W'(AGE);

    logic [lz77we_pkg::BYTE_W-1:0] hist_reg;
    logic                          cand_reg;
    logic                          cand_next;

    // this cell holds the window byte that the match would compare now
    assign hit = (ctl.start || cand_reg) && (AGE_V < ctl.fill) && (AGE_V >= ctl.len)
                 && (hist_reg == ctl.data);

    assign cand_next = ctl.keep && hit;
    assign hist_out  = hist_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cand_reg <= 1'b0;
        end
        else if (ctl.shift) begin
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.shift) begin
            hist_reg <= hist_in;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lz77_window_encoder.sv
// top level of the greedy lz77 window encoder
`default_nettype none

// Greedy LZ77 encoder over a 30-byte window. Bytes arrive on the bytes channel,
// one request per byte, with last_byte set on the final byte of a string; tokens
// (distance, match_length, next_byte, no_next_byte, end_of_string) leave on the
// tokens channel. The window history sits in a row of cells, one per byte of age,
// and every cell compares its byte with the incoming one in the same cycle, so the
// block takes one byte per clock and a token shows up on the cycle after the byte
// that closes it. Only the output register can hold the input back: a new byte is
// taken whenever that register is empty or being drained. Distance counts back
// from the end of the window to the oldest occurrence of the match; a literal has
// distance and length 0. A match that runs into the end of the string gives a
// token with no_next_byte set and next_byte 0. No clearing pass is needed after
// reset: history bytes are only compared once they were written in the current
// string.
module lz77_window_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    lz77we_byte_if.sink     bytes,
    lz77we_token_if.source  tokens
);

    localparam int W  = lz77we_pkg::WINDOW;
    localparam int LW = lz77we_pkg::LEN_W;
    localparam int BW = lz77we_pkg::BYTE_W;

    // match state
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] best_reg, best_next;   // oldest age still matching

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] dist_reg, dist_next;
    logic [LW-1:0] mlen_reg, mlen_next;
    logic [BW-1:0] nb_reg, nb_next;
    logic          nonext_reg, nonext_next;
    logic          eos_reg, eos_next;

    logic                  take;
    logic                  any_hit;
    logic                  emit;
    logic [W-1:0]          hits;
    logic [BW-1:0]         hist_link [W];
    logic [LW:0]           fill_sum;
    logic [LW-1:0]         hit_top;
    lz77we_pkg::cell_ctl_t ctl;

    // a byte is taken whenever the token slot frees up this cycle
    assign bytes.ready = !out_valid_reg || tokens.ready;
    assign take        = bytes.valid && bytes.ready;

    assign any_hit = |hits;
    assign hit_top = lz77we_pkg::top_index(hits);
    assign emit    = take && (!any_hit || bytes.last_byte);

    always_comb
    begin
        ctl.shift = take;
        ctl.keep  = any_hit && !bytes.last_byte;
        ctl.start = (len_reg == '0);
        ctl.fill  = fill_reg;
        ctl.len   = len_reg;
        ctl.data  = bytes.data_byte;
    end

    // window history: newest byte enters cell 0 and ages one cell per byte
    assign hist_link[0] = bytes.data_byte;

    for (genvar a = 0; a < W; a++) begin : g_cell
        if (a < W - 1) begin : g_mid
            lz77we_cell #(.AGE(a)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .hist_in  (hist_link[a]),
                .hist_out (hist_link[a+1]),
                .hit      (hits[a])
            );
        end
        else begin : g_end
            lz77we_cell #(.AGE(a)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .hist_in  (hist_link[a]),
                .hist_out (),
                .hit      (hits[a])
            );
        end
    end

    // window after a break covers the matched bytes and the breaking byte
    assign fill_sum = {1'b0, fill_reg} + {1'b0, len_reg} + (LW+1)'(1);

    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        best_next = best_reg;
        if (take) begin
            if (bytes.last_byte) begin
                // string done, next string starts with an empty window
                fill_next = '0;
                len_next  = '0;
                best_next = '0;
            end
            else if (any_hit) begin
                // prefix grows, remember its oldest occurrence
                len_next  = len_reg + LW'(1);
                best_next = hit_top;
            end
            else begin
                fill_next = (fill_sum > (LW+1)'(W)) ? LW'(W) : fill_sum[LW-1:0];
                len_next  = '0;
                best_next = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !tokens.ready;
        dist_next      = dist_reg;
        mlen_next      = mlen_reg;
        nb_next        = nb_reg;
        nonext_next    = nonext_reg;
        eos_next       = eos_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            eos_next       = bytes.last_byte;
            if (any_hit) begin
                // match ran into the end of the string
                dist_next   = hit_top + LW'(1);
                mlen_next   = len_reg + LW'(1);
                nb_next     = '0;
                nonext_next = 1'b1;
            end
            else if (len_reg == '0) begin
                // literal
                dist_next   = '0;
                mlen_next   = '0;
                nb_next     = bytes.data_byte;
                nonext_next = 1'b0;
            end
            else begin
                // match broken by this byte
                dist_next   = best_reg + LW'(1);
                mlen_next   = len_reg;
                nb_next     = bytes.data_byte;
                nonext_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill_reg      <= '0;
            len_reg       <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // token payload, no reset needed
    always_ff @(posedge clk) begin
        dist_reg   <= dist_next;
        mlen_reg   <= mlen_next;
        nb_reg     <= nb_next;
        nonext_reg <= nonext_next;
        eos_reg    <= eos_next;
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.distance      = dist_reg;
    assign tokens.match_length  = mlen_reg;
    assign tokens.next_byte     = nb_reg;
    assign tokens.no_next_byte  = nonext_reg;
    assign tokens.end_of_string = eos_reg;

    // window never grows past the cell row
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(W))
        else $error("window fill above window size");

    // an open match always lies inside its window
    a_len_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= fill_reg)
        else $error("match length beyond window fill");

    // an open match has its oldest occurrence no younger than its length minus one, inside the window
    a_best_age: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (best_reg >= len_reg - LW'(1)) && (best_reg < fill_reg))
        else $error("oldest match age out of range");

    // the final byte always closes the string with a token
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && bytes.last_byte) |=> out_valid_reg && eos_reg
                                      && fill_reg == '0 && len_reg == '0)
        else $error("string end not closed");

endmodule

`default_nettype wire
